// ----- hdl/edf_tick_scheduler_unit_macros.svh -----
// Assertion macros shared by the scheduler RTL.
`ifndef EDF_TICK_SCHEDULER_UNIT_MACROS_SVH
`define EDF_TICK_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define EDFTS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Next-cycle implication, checked outside reset.
`define EDFTS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

// ----- hdl/edfts_pkg.sv -----
// Shared types and constants of the EDF tick scheduler.
`default_nettype none

package edfts_pkg;

    localparam int TASK_IDX_W = 2;
    localparam int REG_W      = 16;
    localparam int CFG_IDX_W  = 4;

    // Bit 0 of a register index selects period or burst of a task.
    localparam logic REG_KIND_PERIOD = 1'b0;
    localparam logic REG_KIND_BURST  = 1'b1;

    typedef struct packed {
        logic                  valid;
        logic [TASK_IDX_W-1:0] index;
        logic                  done;
    } cell_link_t;

    typedef struct packed {
        logic             period_we;
        logic             burst_we;
        logic [REG_W-1:0] data;
    } cfg_wr_t;

endpackage

`default_nettype wire

// ----- hdl/edfts_cell.sv -----
// One task cell: its registers, release logic and a link of the deadline chain.
`default_nettype none

module edfts_cell
    import edfts_pkg::*;
#(
    parameter int CELL_INDEX  = 0,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire cfg_wr_t                cfg_wr,
    input  wire logic                   tick_en,
    input  wire logic                   restart,
    input  wire cell_link_t             link_in,
    input  wire logic [COUNT_WIDTH-1:0] dl_in,
    output cell_link_t                  link_out,
    output logic [COUNT_WIDTH-1:0]      dl_out,
    input  wire cell_link_t             winner
);

    localparam logic [TASK_IDX_W-1:0] CELL_IDX = TASK_IDX_W'(CELL_INDEX);
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    logic [REG_W-1:0]       period_reg;
    logic [REG_W-1:0]       burst_reg;
    logic [COUNT_WIDTH-1:0] phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] work_reg, work_next;

    logic [COUNT_WIDTH-1:0] per_c, burst_c, phase_eff, work_eff, deadline, phase_inc;
    logic                   enabled, cand, take, win;

    always_comb begin
        per_c     = COUNT_WIDTH'(period_reg);
        burst_c   = COUNT_WIDTH'(burst_reg);
        enabled   = (per_c != '0);
        phase_eff = (restart || (phase_reg >= per_c)) ? '0 : phase_reg;
        work_eff  = (phase_eff == '0) ? burst_c : work_reg;
        deadline  = per_c - phase_eff;
        cand      = enabled && (work_eff != '0);
        take      = cand && (!link_in.valid || (deadline < dl_in));

        if (take) begin
            link_out.valid = 1'b1;
            link_out.index = CELL_IDX;
            link_out.done  = (work_eff == CNT_ONE);
            dl_out         = deadline;
        end else begin
            link_out = link_in;
            dl_out   = dl_in;
        end
    end

    always_comb begin
        win       = winner.valid && (winner.index == CELL_IDX);
        phase_inc = phase_eff + CNT_ONE;

        if (!enabled) begin
            phase_next = '0;
            work_next  = '0;
        end else begin
            phase_next = (phase_inc >= per_c) ? '0 : phase_inc;
            work_next  = win ? (work_eff - CNT_ONE) : work_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= '0;
            burst_reg  <= '0;
            phase_reg  <= '0;
            work_reg   <= '0;
        end else begin
            if (cfg_wr.period_we) begin
                period_reg <= cfg_wr.data;
            end
            if (cfg_wr.burst_we) begin
                burst_reg <= cfg_wr.data;
            end
            if (tick_en) begin
                phase_reg <= phase_next;
                work_reg  <= work_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/edf_tick_scheduler_unit.sv -----
// Top level of the earliest-deadline-first tick scheduler.
//
//  Channel | Ports                                    | Direction | Content
//  --------+------------------------------------------+-----------+--------------------------
//  tick in | s_tvalid, s_tready, s_tdata[7:0]         | in        | restart
//  result  | m_tvalid, m_tready, m_tdata[7:0]         | out       | busy_res, task_number, job_done
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in        | period/burst register write
//
// One tick is accepted per cycle unless the result output is stalled; its result appears in the
// output register on the next cycle. The selection runs combinationally through the chain of task cells.
// Reset is synchronous and active low; it clears all registers, counters and the output.
// A new tick is taken whenever the output register is empty or is being read in the same
// cycle; configuration writes are always accepted.
`default_nettype none

module edf_tick_scheduler_unit
    import edfts_pkg::*;
#(
    parameter int NUM_TASKS   = 4,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [0] restart
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,   // [0] busy_res, [2:1] task_number, [3] job_done
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [REG_W-1:0]     cfg_data
);

`include "edf_tick_scheduler_unit_macros.svh"

    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       tick_en;

    cell_link_t             link   [NUM_TASKS+1];
    logic [COUNT_WIDTH-1:0] dl     [NUM_TASKS+1];
    cfg_wr_t                cfg_wr [NUM_TASKS];
    cell_link_t             winner;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign tick_en   = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign link[0] = '0;
    assign dl[0]   = '0;
    assign winner  = link[NUM_TASKS];

    for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
        always_comb begin
            cfg_wr[i].period_we = cfg_valid
                && (cfg_index[CFG_IDX_W-1:1] == (CFG_IDX_W-1)'(i))
                && (cfg_index[0] == REG_KIND_PERIOD);
            cfg_wr[i].burst_we  = cfg_valid
                && (cfg_index[CFG_IDX_W-1:1] == (CFG_IDX_W-1)'(i))
                && (cfg_index[0] == REG_KIND_BURST);
            cfg_wr[i].data      = cfg_data;
        end

        edfts_cell #(
            .CELL_INDEX  (i),
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cfg_wr   (cfg_wr[i]),
            .tick_en  (tick_en),
            .restart  (s_tdata[0]),
            .link_in  (link[i]),
            .dl_in    (dl[i]),
            .link_out (link[i+1]),
            .dl_out   (dl[i+1]),
            .winner   (winner)
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end else if (tick_en) begin
            m_tvalid_reg <= 1'b1;
            m_tdata_reg  <= {4'b0000, winner.done, winner.index, winner.valid};
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    `EDFTS_ASSERT_NOW(a_idle_clean, aclk, aresetn, m_tvalid && !m_tdata[0], m_tdata[3:1] == 3'b000)
    `EDFTS_ASSERT_NOW(a_stall_blocks, aclk, aresetn, m_tvalid && !m_tready, !s_tready)
    `EDFTS_ASSERT_NEXT(a_tick_result, aclk, aresetn, s_tvalid && s_tready, m_tvalid)

endmodule

`default_nettype wire
